[hdl/mi_pkg.sv]
package mi_pkg;

    // Entry format: signed fixed point, DW bits with FB fractional bits.
    localparam int DW = 32;
    localparam int FB = 16;
    // Exact cofactor: the difference of two full products.
    localparam int CW = 2 * DW + 1;
    // Exact determinant: the sum of three entry-by-cofactor products.
    localparam int DTW = 3 * DW + 3;
    // Width of the long division datapath. It holds the doubled divisor shifted by DW.
    localparam int XW = DTW + DW + 2;
    localparam int LANES = 9;

    typedef struct packed {
        logic signed [DW-1:0] m00, m01, m02;
        logic signed [DW-1:0] m10, m11, m12;
        logic signed [DW-1:0] m20, m21, m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [DW-1:0] r00, r01, r02;
        logic signed [DW-1:0] r10, r11, r12;
        logic signed [DW-1:0] r20, r21, r22;
        logic signed [DW-1:0] det_value;
        logic                 singular;
    } t_mat_out;

    // Per-item state carried through the division pipeline.
    typedef struct packed {
        logic [LANES-1:0][XW-1:0] rem;
        logic [LANES-1:0][DW-1:0] quo;
        logic [LANES-1:0]         neg;
        logic [LANES-1:0]         ovf;
        logic [XW-1:0]            d2;
        logic [DW-1:0]            det_out;
        logic                     singular;
    } t_div_state;

endpackage

[hdl/mi_front.sv]
module mi_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mi_pkg::t_mat_in    i_mat,
    output logic               o_valid,
    output mi_pkg::t_div_state o_state
);
    import mi_pkg::*;

    logic signed [DW-1:0]   a [9];
    logic [4:0]             r_vld;
    logic signed [2*DW-1:0] r_pa [9];
    logic signed [2*DW-1:0] r_pb [9];
    logic signed [2*DW-1:0] n_pa [9];
    logic signed [2*DW-1:0] n_pb [9];
    logic signed [DW-1:0]   r_row0 [3];
    logic signed [DW-1:0]   r_row0b [3];
    logic signed [CW-1:0]   r_cof [9];
    logic signed [CW-1:0]   n_cof [9];
    logic signed [CW-1:0]   r_cof2 [9];
    logic signed [CW-1:0]   r_cof3 [9];
    logic signed [2*DW:0]   r_pl [3];
    logic signed [2*DW:0]   r_ph [3];
    logic signed [2*DW:0]   n_pl [3];
    logic signed [2*DW:0]   n_ph [3];
    logic signed [DTW-1:0]  r_det;
    logic signed [DTW-1:0]  n_det;
    t_div_state             r_state;
    t_div_state             n_state;

    // Flatten the incoming beat into an indexable array, row by row.
    always_comb begin
        a[0] = i_mat.m00;
        a[1] = i_mat.m01;
        a[2] = i_mat.m02;
        a[3] = i_mat.m10;
        a[4] = i_mat.m11;
        a[5] = i_mat.m12;
        a[6] = i_mat.m20;
        a[7] = i_mat.m21;
        a[8] = i_mat.m22;
    end

    // Stage 1: the two products of every 2x2 minor.
    always_comb begin
        int r0, r1, c0, c1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                n_pa[i*3+j] = a[r0*3+c0] * a[r1*3+c1];
                n_pb[i*3+j] = a[r0*3+c1] * a[r1*3+c0];
            end
        end
    end

    // Stage 2: signed cofactors.
    always_comb begin
        logic signed [CW-1:0] mn;
        for (int l = 0; l < 9; l++) begin
            mn = CW'(r_pa[l]) - CW'(r_pb[l]);
            n_cof[l] = (((l / 3) + (l % 3)) % 2 == 1) ? -mn : mn;
        end
    end

    // Stage 3: row-0 entry times cofactor, split into a low and a high partial product.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_pl[j] = r_row0b[j] * $signed({1'b0, r_cof[j][DW-1:0]});
            n_ph[j] = r_row0b[j] * $signed(r_cof[j][CW-1:DW]);
        end
    end

    // Stage 4: the determinant is the sum of the recombined partial products.
    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DTW'(r_ph[j]) <<< DW) + DTW'(r_pl[j]);
        end
    end

    // Stage 5: magnitudes and signs, numerators, the divisor and the rounded determinant.
    always_comb begin
        logic            dneg;
        logic [DTW-1:0]  dabs;
        logic [CW-1:0]   cabs;
        logic [XW-1:0]   rnd;
        logic [XW-1:0]   lim;
        logic [XW-1:0]   mag;
        logic [DW-1:0]   m;
        dneg = r_det[DTW-1];
        dabs = dneg ? DTW'(-r_det) : DTW'(r_det);
        n_state = '0;
        n_state.singular = (r_det == '0);
        n_state.d2 = XW'(dabs) << 1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // The inverse entry at row i, column j takes the cofactor at row j, column i.
                cabs = r_cof3[j*3+i][CW-1] ? CW'(-r_cof3[j*3+i]) : CW'(r_cof3[j*3+i]);
                n_state.neg[i*3+j] = r_cof3[j*3+i][CW-1] ^ dneg;
                n_state.rem[i*3+j] = (XW'(cabs) << (2 * FB + 1)) + XW'(dabs);
                n_state.ovf[i*3+j] = n_state.rem[i*3+j] >= (n_state.d2 << DW);
            end
        end
        rnd = ((XW'(dabs) << 1) + (XW'(1) << (2 * FB))) >> (2 * FB + 1);
        lim = dneg ? (XW'(1) << (DW - 1)) : ((XW'(1) << (DW - 1)) - XW'(1));
        mag = (rnd > lim) ? lim : rnd;
        m = mag[DW-1:0];
        n_state.det_out = dneg ? -m : m;
    end

    // Valid bits travel alongside the data and advance with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa    <= n_pa;
            r_pb    <= n_pb;
            r_row0  <= a[0:2];
            r_cof   <= n_cof;
            r_row0b <= r_row0;
            r_pl    <= n_pl;
            r_ph    <= n_ph;
            r_cof2  <= r_cof;
            r_det   <= n_det;
            r_cof3  <= r_cof2;
            r_state <= n_state;
        end
    end

    assign o_valid = r_vld[4];
    assign o_state = r_state;

endmodule

[hdl/mi_divider.sv]
module mi_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  mi_pkg::t_div_state i_state,
    output logic               o_valid,
    output mi_pkg::t_div_state o_state
);
    import mi_pkg::*;

    t_div_state r_st [DW];
    t_div_state n_st [DW];
    t_div_state w_in [DW];
    logic [DW-1:0] r_vld;

    // One restoring step per stage, most significant quotient bit first, nine lanes side by side.
    for (genvar s = 0; s < DW; s++) begin : g_step
        if (s == 0) begin : g_first
            assign w_in[s] = i_state;
        end else begin : g_next
            assign w_in[s] = r_st[s-1];
        end

        always_comb begin
            logic [XW:0] diff;
            n_st[s] = w_in[s];
            for (int l = 0; l < LANES; l++) begin
                diff = {1'b0, w_in[s].rem[l]} - {1'b0, w_in[s].d2 << (DW - 1 - s)};
                if (!diff[XW]) begin
                    n_st[s].rem[l] = diff[XW-1:0];
                    n_st[s].quo[l][DW-1-s] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DW-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_state = r_st[DW-1];

endmodule

[hdl/matrix3x3_inverse_unit.sv]
// 3x3 matrix inverse, signed Q16.16. One matrix beat can be accepted every clock cycle while
// o_stall is low. Each beat passes through the products, cofactors and determinant, then the
// long division (one quotient bit per stage for all nine entries at once), then sign handling,
// saturation and the output register. The result carries the determinant, rounded and
// saturated. A zero determinant sets singular and returns zero in every other field. A
// two-entry output buffer absorbs a stall, and the input is stalled only while that buffer
// is full.
module matrix3x3_inverse_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mi_pkg::t_mat_in  i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output mi_pkg::t_mat_out o_data
);
    import mi_pkg::*;

    logic       en;
    logic       front_valid;
    t_div_state front_state;
    logic       div_valid;
    t_div_state div_state;
    t_mat_out   fmt;
    logic [DW-1:0] ent [LANES];
    logic       take;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       n_out_valid;
    logic       n_skid_valid;
    t_mat_out   r_out;
    t_mat_out   r_skid;
    t_mat_out   n_out;
    t_mat_out   n_skid;

    // The whole pipeline advances while the skid entry is free.
    assign en = !r_skid_valid;

    mi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mat   (i_data),
        .o_valid (front_valid),
        .o_state (front_state)
    );

    mi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_state (front_state),
        .o_valid (div_valid),
        .o_state (div_state)
    );

    // Apply the sign and saturate each quotient. A singular matrix yields zeros.
    always_comb begin
        logic [DW-1:0] lim;
        logic [DW-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            lim = div_state.neg[l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            mag = (div_state.ovf[l] || div_state.quo[l] > lim) ? lim : div_state.quo[l];
            ent[l] = div_state.singular ? '0 : (div_state.neg[l] ? -mag : mag);
        end
        fmt.r00 = ent[0];
        fmt.r01 = ent[1];
        fmt.r02 = ent[2];
        fmt.r10 = ent[3];
        fmt.r11 = ent[4];
        fmt.r12 = ent[5];
        fmt.r20 = ent[6];
        fmt.r21 = ent[7];
        fmt.r22 = ent[8];
        fmt.det_value = div_state.singular ? '0 : div_state.det_out;
        fmt.singular = div_state.singular;
    end

    // Output register plus one skid entry.
    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                n_out       = fmt;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = fmt;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a beat while the output register is empty");

    // The skid entry fills only when the output was full and stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid entry filled without a stalled output");

    // A singular result carries zeros.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> (o_data.det_value == '0 && o_data.r00 == '0
            && o_data.r11 == '0 && o_data.r22 == '0))
        else $error("singular result with nonzero fields");
`endif

endmodule

[test/tb_matrix3x3_inverse_unit.sv]
module tb_matrix3x3_inverse_unit;
    import mi_pkg::*;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hFFFF_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam int N_RANDOM = 1500;

    typedef logic [31:0] t_fields [11];
    typedef struct {
        t_mat_in  m;
        bit       typed;
        t_mat_out want;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_mat_in  i_data = '0;
    logic     o_stall;
    logic     o_valid;
    t_mat_out o_data;

    t_mat_out inverse_due[$];
    t_row     directed_rows[$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       singular_seen = 0;
    bit       rx_busy_mode = 1'b0;
    int       rx_wait = 0;

    matrix3x3_inverse_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Round num/den to nearest, ties away from zero, and saturate to 32 bits.
    function automatic logic [31:0] round_sat(logic signed [191:0] num, logic [191:0] den);
        logic        neg;
        logic [191:0] mag, q, lim;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (2 * mag + den) / (2 * den);
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // Exact adjugate inverse with the determinant taken along the first row.
    function automatic t_mat_out inverse_of(t_mat_in m);
        logic signed [191:0] a [3][3];
        logic signed [191:0] cof [3][3];
        logic signed [191:0] det, mn, num;
        logic [191:0] dabs;
        logic [31:0] v [9];
        logic [31:0] flat [9];
        t_mat_out res;
        int r0, r1, c0, c1;
        flat = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = {{160{flat[i*3+j][31]}}, flat[i*3+j]};
        for (int i = 0; i < 3; i++) begin
            r0 = (i == 0) ? 1 : 0;
            r1 = (i == 2) ? 1 : 2;
            for (int j = 0; j < 3; j++) begin
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                mn = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
                cof[i][j] = ((i + j) % 2 == 1) ? -mn : mn;
            end
        end
        det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        dabs = (det < 0) ? -det : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                num = cof[j][i] <<< 32;
                if (det < 0) num = -num;
                v[i*3+j] = round_sat(num, dabs);
            end
        res.r00 = v[0]; res.r01 = v[1]; res.r02 = v[2];
        res.r10 = v[3]; res.r11 = v[4]; res.r12 = v[5];
        res.r20 = v[6]; res.r21 = v[7]; res.r22 = v[8];
        res.det_value = round_sat(det, 192'h1_0000_0000);
        return res;
    endfunction

    function automatic t_fields fields_of(t_mat_out o);
        t_fields f;
        f = '{o.r00, o.r01, o.r02, o.r10, o.r11, o.r12, o.r20, o.r21, o.r22,
              o.det_value, {31'b0, o.singular}};
        return f;
    endfunction

    function automatic t_mat_in diag(logic [31:0] d);
        t_mat_in m;
        m = '0;
        m.m00 = d; m.m11 = d; m.m22 = d;
        return m;
    endfunction

    function automatic t_mat_out diag_inv(logic [31:0] r, logic [31:0] dv);
        t_mat_out o;
        o = '0;
        o.r00 = r; o.r11 = r; o.r22 = r;
        o.det_value = dv;
        return o;
    endfunction

    // Entry drawn from one of several value classes.
    function automatic logic [31:0] pick_entry(int kind);
        logic [31:0] e;
        case (kind)
            0: e = $urandom;
            1: e = 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            2: e = 32'($signed($urandom_range(0, 255)) - 128);
            default: begin
                case ($urandom_range(0, 5))
                    0: e = SMAX;
                    1: e = SMIN;
                    2: e = ONE;
                    3: e = MONE;
                    4: e = '0;
                    default: e = $urandom;
                endcase
            end
        endcase
        return e;
    endfunction

    function automatic t_mat_in random_matrix();
        t_mat_in m;
        int kind, sel;
        sel = $urandom_range(0, 99);
        kind = (sel < 35) ? 1 : (sel < 65) ? 0 : (sel < 80) ? 3 : 2;
        m.m00 = pick_entry(kind); m.m01 = pick_entry(kind); m.m02 = pick_entry(kind);
        m.m10 = pick_entry(kind); m.m11 = pick_entry(kind); m.m12 = pick_entry(kind);
        m.m20 = pick_entry(kind); m.m21 = pick_entry(kind); m.m22 = pick_entry(kind);
        // Some matrices are made singular on purpose.
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: begin m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02; end
                1: begin m.m01 = '0; m.m11 = '0; m.m21 = '0; end
                default: begin m.m12 = -m.m02; m.m11 = -m.m01; m.m10 = -m.m00; end
            endcase
        end
        return m;
    endfunction

    // Offer one matrix beat, after a random gap unless quiet, and hold it until accepted.
    task automatic send_matrix(t_mat_in m, bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        do @(posedge i_clk); while (o_stall);
        inverse_due.push_back(inverse_of(m));
    endtask

    // Result side: random stall lengths outside busy mode, and every accepted beat checked.
    always @(posedge i_clk) begin
        t_fields got, want;
        t_mat_out exp_beat;
        int draw;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_data.singular) singular_seen++;
                if (inverse_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result beat: %p", o_data);
                end else begin
                    exp_beat = inverse_due.pop_front();
                    got  = fields_of(o_data);
                    want = fields_of(exp_beat);
                    for (int k = 0; k < 11; k++)
                        if (got[k] !== want[k]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("Result %0d field %0d: expected %h, got %h",
                                         results_seen, k, want[k], got[k]);
                        end
                end
                draw = rx_busy_mode ? 0 : $urandom_range(0, 13);
                rx_wait = draw;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Overall time limit.
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_mat_out want;
        bit quiet;
        // Directed rows; expectations typed in where obvious.
        want = '0; want.singular = 1'b1;
        directed_rows.push_back('{'0, 1'b1, want});
        directed_rows.push_back('{{9{SMAX}}, 1'b1, want});
        directed_rows.push_back('{{9{SMIN}}, 1'b1, want});
        directed_rows.push_back('{diag(ONE), 1'b1, diag_inv(ONE, ONE)});
        directed_rows.push_back('{diag(MONE), 1'b1, diag_inv(MONE, MONE)});
        // Determinant of 2^-48: rounds to zero, yet the inverse saturates.
        directed_rows.push_back('{diag(32'd1), 1'b1, diag_inv(SMAX, '0)});
        directed_rows.push_back('{diag(SMIN), 1'b1, diag_inv(32'hFFFF_FFFE, SMIN)});
        directed_rows.push_back('{diag(SMAX), 1'b1, diag_inv(32'd2, SMAX)});
        directed_rows.push_back('{diag(32'hFFFF_FFFF), 1'b1, diag_inv(SMIN, '0)});
        directed_rows.push_back('{{SMAX, SMIN, ONE, MONE, SMAX, 32'h0, ONE, SMIN, SMAX},
                                  1'b0, want});
        directed_rows.push_back('{{ONE, ONE, 32'h0, 32'h0, ONE, ONE, ONE, 32'h0, ONE},
                                  1'b0, want});
        directed_rows.push_back('{{32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F,
                                   32'hF0F0_F0F0, 32'hAAAA_AAAA, 32'h5555_5555,
                                   32'h3333_3333, 32'hCCCC_CCCC, 32'hAAAA_AAAA}, 1'b0, want});
        directed_rows.push_back('{{SMIN, SMAX, SMAX, SMAX, SMIN, SMAX, SMAX, SMAX, SMIN},
                                  1'b0, want});
        directed_rows.push_back('{{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
                                   32'd7, 32'd8, 32'd10}, 1'b0, want});

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a typed expectation must agree with the predictor too.
        foreach (directed_rows[n]) begin
            if (directed_rows[n].typed &&
                fields_of(directed_rows[n].want) != fields_of(inverse_of(directed_rows[n].m))) begin
                mismatches++;
                if (mismatches <= 10) $display("Directed row %0d: predictor disagrees", n);
            end
            send_matrix(directed_rows[n].m, 1'b0);
        end

        // Random part, with stretches of full rate on either side.
        quiet = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
                rx_busy_mode = ($urandom_range(0, 2) == 0);
            end
            send_matrix(random_matrix(), quiet);
        end
        i_valid <= 1'b0;
        rx_busy_mode = 1'b1;

        // Drain, then allow for any stray beat.
        while (inverse_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Inverted %0d matrices, %0d of them singular, with random gaps and stalls.",
                 results_seen, singular_seen);
        if (mismatches == 0 && inverse_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
